### hw/rtl/dpt_pkg.sv
`default_nettype none
package dpt_pkg;

  // Width of the candidate number.
  localparam int NUM_BITS = 32;
  localparam int CNT_BITS = (NUM_BITS > 2) ? $clog2(NUM_BITS) : 1;
  localparam int WIT_BITS = 32;

  typedef logic [NUM_BITS-1:0] num_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [1:0]          widx_t;

  // Operand selection for the shared modular multiplier.
  typedef enum logic [1:0] {
    MUL_X_B = 2'd0,
    MUL_B_B = 2'd1,
    MUL_X_X = 2'd2
  } mul_op_t;

  localparam widx_t WIT_LAST = 2'd3;

  // Witness bases in test order; past the last one the value is all ones, no smaller than any number.
  function automatic logic [WIT_BITS-1:0] witness_f(input widx_t idx);
    logic [WIT_BITS-1:0] w;
    unique case (idx)
      2'd0:    w = WIT_BITS'(2);
      2'd1:    w = WIT_BITS'(7);
      2'd2:    w = WIT_BITS'(61);
      default: w = '1;
    endcase
    return w;
  endfunction

  typedef struct packed {
    logic    load;
    logic    split_shift;
    logic    wit_init;
    logic    wit_next;
    logic    mul_start;
    mul_op_t mul_op;
    logic    e_shift;
    logic    r_init;
    logic    r_inc;
    logic    res_set;
    logic    res_val;
  } dpt_cmd_t;

  typedef struct packed {
    logic n_is_two;
    logic n_trivial;
    logic d_odd;
    logic e_zero;
    logic e_lsb;
    logic x_is_one;
    logic x_is_nm1;
    logic r_ge_s;
    logic wit_done;
    logic mul_done;
  } dpt_status_t;

endpackage
`default_nettype wire

### hw/rtl/dpt_mulmod.sv
`default_nettype none
module dpt_mulmod (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire dpt_pkg::num_t a,
  input  wire dpt_pkg::num_t b,
  input  wire dpt_pkg::num_t m,
  output logic               done,
  output dpt_pkg::num_t      p
);
  import dpt_pkg::*;

  localparam int TW = NUM_BITS + 2;

  num_t          acc_r, acc_nxt;
  num_t          a_r;
  num_t          b_r;
  num_t          m_r;
  cnt_t          cnt_r;
  logic          run_r;
  logic          done_r;
  logic [TW-1:0] t;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;

  // One multiplier bit per cycle, most significant first: acc = 2*acc + bit*a,
  // which stays below three times the modulus, so one of two subtractions fixes it.
  always_comb begin
    m1 = TW'(m_r);
    m2 = {1'b0, m_r, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (b_r[NUM_BITS-1] ? TW'(a_r) : '0);
    priority if (t >= m2) begin
      acc_nxt = NUM_BITS'(t - m2);
    end else if (t >= m1) begin
      acc_nxt = NUM_BITS'(t - m1);
    end else begin
      acc_nxt = NUM_BITS'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(NUM_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[NUM_BITS-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

### hw/rtl/dpt_datapath.sv
`default_nettype none
module dpt_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dpt_pkg::num_t     in_number,
  input  wire dpt_pkg::dpt_cmd_t cmd,
  output dpt_pkg::dpt_status_t   status,
  output logic                   result
);
  import dpt_pkg::*;

  num_t    n_r;
  num_t    nm1_r;
  num_t    d_r;
  num_t    e_r;
  num_t    x_r;
  num_t    base_r;
  cnt_t    s_r;
  cnt_t    r_r;
  widx_t   widx_r;
  mul_op_t op_r;
  logic    res_r;

  num_t    mul_a;
  num_t    mul_b;
  logic    mul_done;
  num_t    mul_p;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_X_B: begin
        mul_a = x_r;
        mul_b = base_r;
      end
      MUL_B_B: begin
        mul_a = base_r;
        mul_b = base_r;
      end
      MUL_X_X: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = x_r;
      end
    endcase
  end

  dpt_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (n_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= 1'b0;
    end else if (cmd.res_set) begin
      res_r <= cmd.res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= in_number;
      nm1_r  <= in_number - 1'b1;
      d_r    <= in_number - 1'b1;
      s_r    <= '0;
      widx_r <= '0;
    end
    if (cmd.split_shift) begin
      d_r <= d_r >> 1;
      s_r <= s_r + 1'b1;
    end
    if (cmd.wit_init) begin
      x_r    <= NUM_BITS'(1);
      base_r <= NUM_BITS'(witness_f(widx_r));
      e_r    <= d_r;
    end
    if (cmd.wit_next) begin
      widx_r <= widx_r + 1'b1;
    end
    if (cmd.e_shift) begin
      e_r <= e_r >> 1;
    end
    if (cmd.r_init) begin
      r_r <= CNT_BITS'(1);
    end
    if (cmd.r_inc) begin
      r_r <= r_r + 1'b1;
    end
    if (cmd.mul_start) begin
      op_r <= cmd.mul_op;
    end
    // The product goes back to the register that the operation names.
    if (mul_done) begin
      if (op_r == MUL_B_B) begin
        base_r <= mul_p;
      end else begin
        x_r <= mul_p;
      end
    end
  end

  always_comb begin
    status.n_is_two  = (n_r == NUM_BITS'(2));
    status.n_trivial = (n_r < NUM_BITS'(2)) || !n_r[0];
    status.d_odd     = d_r[0];
    status.e_zero    = (e_r == '0);
    status.e_lsb     = e_r[0];
    status.x_is_one  = (x_r == NUM_BITS'(1));
    status.x_is_nm1  = (x_r == nm1_r);
    status.r_ge_s    = (r_r >= s_r);
    status.wit_done  = (widx_r == WIT_LAST) ||
                       (WIT_BITS'(n_r) <= witness_f(widx_r));
    status.mul_done  = mul_done;
  end

  assign result = res_r;

endmodule
`default_nettype wire

### hw/rtl/dpt_ctrl.sv
`default_nettype none
module dpt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire dpt_pkg::dpt_status_t status,
  output dpt_pkg::dpt_cmd_t         cmd,
  output logic                      busy,
  output logic                      done
);
  import dpt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLASS = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_WIT   = 4'd3;
  localparam logic [3:0] S_POW   = 4'd4;
  localparam logic [3:0] S_MACC  = 4'd5;
  localparam logic [3:0] S_MSQB  = 4'd6;
  localparam logic [3:0] S_CHK1  = 4'd7;
  localparam logic [3:0] S_SQL   = 4'd8;
  localparam logic [3:0] S_MSQX  = 4'd9;
  localparam logic [3:0] S_SQE   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_op = MUL_X_B;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (status.n_is_two) begin
          cmd.res_set = 1'b1;
          cmd.res_val = 1'b1;
          state_nxt   = S_DONE;
        end else if (status.n_trivial) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!status.d_odd) begin
          cmd.split_shift = 1'b1;
        end else begin
          state_nxt = S_WIT;
        end
      end
      S_WIT: begin
        // Every witness that applies has been passed.
        if (status.wit_done) begin
          cmd.res_set = 1'b1;
          cmd.res_val = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.wit_init = 1'b1;
          state_nxt    = S_POW;
        end
      end
      S_POW: begin
        priority if (status.e_zero) begin
          state_nxt = S_CHK1;
        end else if (status.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_X_B;
          state_nxt     = S_MACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_B_B;
          state_nxt     = S_MSQB;
        end
      end
      S_MACC: begin
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_B_B;
          state_nxt     = S_MSQB;
        end
      end
      S_MSQB: begin
        if (status.mul_done) begin
          cmd.e_shift = 1'b1;
          state_nxt   = S_POW;
        end
      end
      S_CHK1: begin
        if (status.x_is_one || status.x_is_nm1) begin
          cmd.wit_next = 1'b1;
          state_nxt    = S_WIT;
        end else begin
          cmd.r_init = 1'b1;
          state_nxt  = S_SQL;
        end
      end
      S_SQL: begin
        if (status.r_ge_s) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_X_X;
          state_nxt     = S_MSQX;
        end
      end
      S_MSQX: begin
        if (status.mul_done) begin
          cmd.r_inc = 1'b1;
          state_nxt = S_SQE;
        end
      end
      S_SQE: begin
        if (status.x_is_nm1) begin
          cmd.wit_next = 1'b1;
          state_nxt    = S_WIT;
        end else begin
          state_nxt = S_SQL;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule
`default_nettype wire

### hw/rtl/deterministic_primality_test_32.sv
// Channel   Ports                         Handshake
// input     in_number[31:0]               taken when start is high and busy is low
// result    out_is_prime_flag             shown for one cycle while out_valid is high
//
// Words 0, 1 and 2 and even numbers are settled without the multiplier; the longest
// word is a large odd number tested against all three witnesses.
// Its run time is set by the shared modular multiplier, which retires one
// multiplier bit per cycle, and by up to 62 products a witness.
// Reset is synchronous and active low and returns the controller to idle.
// The receiver cannot stall: the result is shown while the controller is in its done state, which then drops busy.
`default_nettype none
module deterministic_primality_test_32 (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire dpt_pkg::num_t in_number,
  output logic               out_valid,
  output logic               out_is_prime_flag
);
  import dpt_pkg::*;

  dpt_cmd_t    cmd;
  dpt_status_t status;

  dpt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  dpt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_number (in_number),
    .cmd       (cmd),
    .status    (status),
    .result    (out_is_prime_flag)
  );

endmodule
`default_nettype wire

### hw/rtl/dpt_checker.sv
`default_nettype none
module dpt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A result never appears in the cycle right after acceptance.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result shown too early");

  // The result is shown while busy, and the block goes idle straight after.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_valid_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block still busy after delivering a result");

endmodule

bind deterministic_primality_test_32 dpt_checker u_dpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
  import dpt_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 7000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_WORDS = 100;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  num_t in_number;
  logic out_valid;
  logic out_is_prime_flag;

  logic prime_flag_q[$];
  int   fail_count;
  int   cycle_count;

  typedef struct packed {
    num_t number;
    logic typed;
    logic flag;
  } dir_row_t;

  // Rows with typed set carry their expected flag in the table; the rest go to the predictor.
  dir_row_t dir_rows [23] = '{
    '{32'd0,          1'b1, 1'b0},
    '{32'd1,          1'b1, 1'b0},
    '{32'd2,          1'b1, 1'b1},
    '{32'd3,          1'b0, 1'b0},
    '{32'd4,          1'b1, 1'b0},
    '{32'd5,          1'b0, 1'b0},
    '{32'd7,          1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0},
    '{32'd61,         1'b0, 1'b0},
    '{32'd63,         1'b0, 1'b0},
    '{32'd67,         1'b0, 1'b0},
    '{32'd561,        1'b0, 1'b0},
    '{32'd2047,       1'b0, 1'b0},
    '{32'd3277,       1'b0, 1'b0},
    '{32'd4033,       1'b0, 1'b0},
    '{32'd65537,      1'b0, 1'b0},
    '{32'd1373653,    1'b0, 1'b0},
    '{32'd3215031751, 1'b0, 1'b0},
    '{32'd2147483647, 1'b0, 1'b0},
    '{32'd2147483648, 1'b1, 1'b0},
    '{32'd4294967291, 1'b1, 1'b1},
    '{32'd4294967294, 1'b1, 1'b0},
    '{32'd4294967295, 1'b1, 1'b0}
  };

  deterministic_primality_test_32 u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_is_prime_flag (out_is_prime_flag)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] mod_product(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] m);
    return (a * b) % m;
  endfunction

  // Strong probable-prime round for odd n of at least 3.
  function automatic logic passes_witness(input logic [63:0] w, input logic [63:0] n);
    logic [63:0] d;
    logic [63:0] e;
    logic [63:0] b;
    logic [63:0] x;
    int          s;
    d = n - 64'd1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = 64'd1;
    b = w % n;
    e = d;
    while (e != 64'd0) begin
      if (e[0]) x = mod_product(x, b, n);
      b = mod_product(b, b, n);
      e = e >> 1;
    end
    if (x == 64'd1 || x == n - 64'd1) return 1'b1;
    for (int r = 1; r < s; r++) begin
      x = mod_product(x, x, n);
      if (x == n - 64'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic prime_verdict(input num_t number);
    logic [63:0] n;
    n = {32'd0, number};
    if (n == 64'd2) return 1'b1;
    if (n < 64'd2 || !n[0]) return 1'b0;
    if (!passes_witness(64'd2, n)) return 1'b0;
    if (n > 64'd7 && !passes_witness(64'd7, n)) return 1'b0;
    if (n > 64'd61 && !passes_witness(64'd61, n)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic num_t pick_prime(input int unsigned lo, input int unsigned hi);
    num_t c;
    c = num_t'($urandom_range(hi, lo)) | num_t'(1);
    for (int i = 0; i < 2000 && !prime_verdict(c); i++)
      c = num_t'($urandom_range(hi, lo)) | num_t'(1);
    return c;
  endfunction

  // Mostly odd candidates, primes and semiprimes, so that all three witnesses get work.
  function automatic num_t pick_number();
    int   kind;
    num_t p;
    num_t q;
    kind = $urandom_range(9, 0);
    case (kind)
      0, 1: begin
        return num_t'($urandom());
      end
      2, 3: begin
        return num_t'($urandom()) | num_t'(1);
      end
      4, 5: begin
        return pick_prime(3, 32'hFFFF_FFFF);
      end
      6: begin
        p = pick_prime(3, 65535);
        q = pick_prime(3, 65535);
        return p * q;
      end
      7: begin
        return num_t'($urandom_range(300, 0));
      end
      8: begin
        return 32'hFFFF_FFFF - num_t'($urandom_range(64, 0));
      end
      default: begin
        return num_t'($urandom_range(8191, 0)) | num_t'(1);
      end
    endcase
  endfunction

  function automatic int pick_gap(input logic quiet);
    int r;
    r = $urandom_range(99, 0);
    if (quiet) return 0;
    if (r < 70) return $urandom_range(3, 0);
    if (r < 95) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  // Holds start high from the chosen falling edge until the word is taken.
  task automatic send_word(input num_t number, input logic typed, input logic flag,
                           input int gap);
    repeat (gap) begin
      @(negedge clk);
      start     <= 1'b0;
      in_number <= num_t'($urandom());
    end
    @(negedge clk);
    start     <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (busy);
    prime_flag_q.push_back(typed ? flag : prime_verdict(number));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (prime_flag_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: flag %0b", out_is_prime_flag);
      end else begin
        logic want;
        want = prime_flag_q.pop_front();
        if (out_is_prime_flag !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("flag mismatch: expected %0b, got %0b", want, out_is_prime_flag);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic quiet;
    fail_count  = 0;
    cycle_count = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_number   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].number, dir_rows[i].typed, dir_rows[i].flag, pick_gap(1'b0));

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Every sixteen words, possibly switch to a stretch of back-to-back starts.
      if (i % 16 == 0) quiet = ($urandom_range(2, 0) == 0);
      send_word(pick_number(), 1'b0, 1'b0, pick_gap(quiet));
    end
    @(negedge clk);
    start <= 1'b0;

    while (prime_flag_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
